FILE: hdl/ffc_pkg.sv
// Shared types and constants of the frustum box culling block.
`default_nettype none

package ffc_pkg;

  localparam int NumPlaneRegs = 6;
  localparam int CfgIdxW = 3;
  localparam int CountW = 3;
  localparam int FifoDepth = 2;

  localparam logic [CfgIdxW-1:0] CfgPlaneCount = 3'd6;

  typedef logic signed [15:0] ffc_coord_t;
  typedef logic signed [16:0] ffc_wide_t;

  typedef struct packed {
    logic signed [15:0] d;
    logic [2:0][15:0]   n;
  } ffc_plane_t;

  typedef struct packed {
    logic [2:0][16:0] sum;
    logic [2:0][16:0] diff;
  } ffc_work_t;

endpackage

`default_nettype wire

FILE: hdl/ffc_if.sv
// Handshake interfaces for the box, result and configuration channels.
`default_nettype none

interface ffc_box_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] box_min_x;
  logic signed [15:0] box_min_y;
  logic signed [15:0] box_min_z;
  logic signed [15:0] box_max_x;
  logic signed [15:0] box_max_y;
  logic signed [15:0] box_max_z;

  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, output ready);
endinterface

interface ffc_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

interface ffc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/ffc_front.sv
// Front stage: accepts a box and forms the per-axis corner sums and extents.
`default_nettype none

module ffc_front
  import ffc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ffc_box_if.sink    in_box,
  output ffc_work_t  work_o,
  output logic       work_valid_o,
  input  wire logic  work_ready_i
);

  logic       fv_r;
  ffc_work_t  work_r;
  ffc_work_t  work_nxt;
  ffc_coord_t lo [3];
  ffc_coord_t hi [3];

  assign in_box.ready = !fv_r || work_ready_i;

  always_comb begin
    lo[0] = in_box.box_min_x;
    lo[1] = in_box.box_min_y;
    lo[2] = in_box.box_min_z;
    hi[0] = in_box.box_max_x;
    hi[1] = in_box.box_max_y;
    hi[2] = in_box.box_max_z;
    for (int k = 0; k < 3; k++) begin
      work_nxt.sum[k]  = 17'(hi[k]) + 17'(lo[k]);
      work_nxt.diff[k] = 17'(hi[k]) - 17'(lo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_box.ready) begin
      fv_r <= in_box.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_box.valid && in_box.ready) begin
      work_r <= work_nxt;
    end
  end

  assign work_o       = work_r;
  assign work_valid_o = fv_r;

endmodule

`default_nettype wire

FILE: hdl/ffc_fifo.sv
// Short queue that decouples the front stage from the plane evaluation.
`default_nettype none

module ffc_fifo
  import ffc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_valid_i,
  output logic            wr_ready_o,
  input  wire ffc_work_t  wr_data_i,
  output logic            rd_valid_o,
  input  wire logic       rd_ready_i,
  output ffc_work_t       rd_data_o
);

  localparam int AW = $clog2(FifoDepth);

  ffc_work_t       mem [FifoDepth];
  logic [AW-1:0]   wp_r;
  logic [AW-1:0]   rp_r;
  logic [AW:0]     cnt_r;
  logic [AW:0]     cnt_nxt;
  logic            push;
  logic            pop;

  assign wr_ready_o = (cnt_r != (AW+1)'(FifoDepth));
  assign rd_valid_o = (cnt_r != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ffc_back.sv
// Plane evaluation pipeline: products, axis sums, plane tests and the result register.
`default_nettype none

module ffc_back
  import ffc_pkg::*;
#(
  parameter int MAX_PLANES = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        work_valid_i,
  output logic             work_ready_o,
  input  wire ffc_work_t   work_i,
  input  wire ffc_plane_t  planes_i [MAX_PLANES],
  input  wire logic [CountW-1:0] plane_count_i,
  ffc_res_if.source        out_res
);

  function automatic logic signed [16:0] abs_norm(input logic signed [15:0] n);
    logic signed [16:0] w;
    w = 17'(n);
    return n[15] ? -w : w;
  endfunction

  logic en;
  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [32:0] ps_r   [MAX_PLANES][3];
  logic signed [32:0] ps_nxt [MAX_PLANES][3];
  logic signed [33:0] pd_r   [MAX_PLANES][3];
  logic signed [33:0] pd_nxt [MAX_PLANES][3];
  logic signed [34:0] ax_r   [MAX_PLANES][3];
  logic signed [34:0] ax_nxt [MAX_PLANES][3];
  logic signed [37:0] acc    [MAX_PLANES];
  logic [MAX_PLANES-1:0] rej_r;
  logic [MAX_PLANES-1:0] rej_nxt;
  logic [MAX_PLANES-1:0] en_mask;
  logic [CountW-1:0]     cnt_sat;
  logic vis_r;
  logic vis_nxt;

  assign en           = !v4_r || out_res.ready;
  assign work_ready_o = en;

  always_comb begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      for (int k = 0; k < 3; k++) begin
        ps_nxt[p][k] = 33'($signed(work_i.sum[k])) * 33'($signed(planes_i[p].n[k]));
        pd_nxt[p][k] = 34'($signed(work_i.diff[k])) * 34'(abs_norm($signed(planes_i[p].n[k])));
        ax_nxt[p][k] = 35'(ps_r[p][k]) + 35'(pd_r[p][k]);
      end
    end
  end

  always_comb begin
    cnt_sat = (plane_count_i > CountW'(MAX_PLANES)) ? CountW'(MAX_PLANES) : plane_count_i;
    for (int p = 0; p < MAX_PLANES; p++) begin
      acc[p] = 38'(ax_r[p][0]) + 38'(ax_r[p][1]) + 38'(ax_r[p][2])
             + {{7{planes_i[p].d[15]}}, planes_i[p].d, 15'b0};
      rej_nxt[p] = acc[p][37];
      en_mask[p] = (CountW'(p) < cnt_sat);
    end
    vis_nxt = ~|(rej_r & en_mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= work_valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r  <= ps_nxt;
      pd_r  <= pd_nxt;
      ax_r  <= ax_nxt;
      rej_r <= rej_nxt;
      vis_r <= vis_nxt;
    end
  end

  assign out_res.valid   = v4_r;
  assign out_res.visible = vis_r;

endmodule

`default_nettype wire

FILE: hdl/frustum_box_cull_core.sv
// Top level of the frustum box culling block: plane registers, front, queue and back.
//
//  Channel   Direction  Handshake      Payload
//  in_box    in         valid/ready    box_min_x..z, box_max_x..z (Q12.4)
//  out_res   out        valid/ready    visible
//  cfg_wr    in         valid/ready    index (0..5 planes, 6 plane_count), data
//
// One box is accepted per cycle unless the front register and queue are both full;
// each result passes one front register, the queue and four evaluation stages.
// All planes are tested in parallel lanes, two multipliers per normal component.
// Reset clears the plane registers and the plane count and empties the pipeline.
// A stalled result holds the evaluation stages; the queue and front register keep
// taking boxes until they fill. cfg_wr is always ready.
`default_nettype none

module frustum_box_cull_core
  import ffc_pkg::*;
#(
  parameter int MAX_PLANES = 6
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ffc_box_if.sink    in_box,
  ffc_res_if.source  out_res,
  ffc_cfg_if.sink    cfg_wr
);

  ffc_plane_t        plane_r [MAX_PLANES];
  logic [CountW-1:0] count_r;

  ffc_work_t fr_work;
  logic      fr_valid;
  logic      fq_ready;
  ffc_work_t fq_work;
  logic      fq_valid;
  logic      bk_ready;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < MAX_PLANES; p++) begin
        plane_r[p] <= '0;
      end
      count_r <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      for (int p = 0; p < MAX_PLANES; p++) begin
        if (cfg_wr.index == CfgIdxW'(p)) begin
          plane_r[p] <= ffc_plane_t'(cfg_wr.data);
        end
      end
      if (cfg_wr.index == CfgPlaneCount) begin
        count_r <= cfg_wr.data[CountW-1:0];
      end
    end
  end

  ffc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_box       (in_box),
    .work_o       (fr_work),
    .work_valid_o (fr_valid),
    .work_ready_i (fq_ready)
  );

  ffc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fr_work),
    .rd_valid_o (fq_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (fq_work)
  );

  ffc_back #(
    .MAX_PLANES (MAX_PLANES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .work_valid_i  (fq_valid),
    .work_ready_o  (bk_ready),
    .work_i        (fq_work),
    .planes_i      (plane_r),
    .plane_count_i (count_r),
    .out_res       (out_res)
  );

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_res.valid)
    else $error("result valid right after reset");

  a_stall_holds_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |-> !bk_ready)
    else $error("evaluation pipeline advanced while the result is stalled");

  a_front_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_box.valid && in_box.ready |=> fr_valid)
    else $error("accepted item not held in the front register");
`endif

endmodule

`default_nettype wire
